@@ src/slot_bitmap_allocator_defines.svh @@
// Assertion macros shared by the slot bitmap allocator RTL.
`ifndef SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sba_pkg.sv @@
// Types and constants of the slot bitmap allocator.
package sba_pkg;

    // Slot geometry. All sizes are powers of two so that addresses split by bit fields.
    localparam int SLOT_BYTES     = 16;
    localparam int SLOT_SHIFT     = $clog2(SLOT_BYTES);
    localparam int SLOTS_PER_PAGE = 256;
    localparam int GROUP_SLOTS    = 4;
    localparam int GROUP_MASK     = GROUP_SLOTS - 1;

    // One memory row holds the marks of ROW_SLOTS neighbouring slots.
    localparam int ROW_SLOTS      = 32;
    localparam int LANE_W         = $clog2(ROW_SLOTS);
    localparam int ROWS_PER_PAGE  = SLOTS_PER_PAGE / ROW_SLOTS;
    localparam int ROW_W          = $clog2(ROWS_PER_PAGE);
    localparam int PAGE_SHIFT     = SLOT_SHIFT + LANE_W + ROW_W;

    // Request sizes.
    localparam logic [7:0] ONE_SLOT_SIZE = 8'(SLOT_BYTES);
    localparam logic [7:0] MAX_SIZE      = 8'(2 * SLOT_BYTES);

    // Stream payload widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Request kinds carried in s_tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_IGNORED   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BASE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_LIMIT = 1'b1;
    localparam logic [3:0] PAGE_LIMIT_RESET = 4'd8;

    // Marks of one memory row: double bits above free bits.
    typedef struct packed {
        logic [ROW_SLOTS-1:0] dbl;
        logic [ROW_SLOTS-1:0] free;
    } row_t;

endpackage

@@ src/slot_bitmap_allocator.sv @@
// Slot bitmap allocator: slot marks memory, search sequencer and result register.
//
// Usage. Requests arrive on the s_ stream: s_tuser is the kind (0 allocate, 1 free),
// s_tdata holds the size and the address. Each request gives exactly one result item
// on the m_ stream with a status, the allocated address and the two-slot flag.
// Registers pool_base and page_limit are written through the cfg_wr_ port by the user
// only while idle, unenforced by the block; a write applies at the next clock edge.
//
// Timing. The slot marks live in one memory, 32 slots per row, eight rows per page.
// An allocation reads and checks one row at a time, newest active page first, up to
// 8 rows per active page. A free reads its row and then updates it; a free whose
// address lies outside the active pages skips the read, and a rejected size goes
// straight to the result. One item is in work at a time; s_tready is high only between
// items and rises with m_tvalid.
//
// Reset. aresetn clears the control state, then a clearing pass writes every row, one
// per cycle (NUM_PAGES * 8 rows, 64 at the default), with s_tready low meanwhile.
//
// Stall. A result waits in the output register while m_tready is low. The next item
// is still accepted and worked on; its result is held until the register frees up.
`include "slot_bitmap_allocator_defines.svh"

module slot_bitmap_allocator
    import sba_pkg::*;
#(
    parameter int NUM_PAGES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [31:0]            cfg_wr_data,
    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] size, [39:8] address
    input  logic [0:0]             s_tuser,   // [0] func
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [1:0] status, [33:2] address_out,
                                              // [34] two_slots, [39:35] zero
);

    // Derived sizes.
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int AP_W   = $clog2(NUM_PAGES + 1);
    localparam int ADDR_W = PAGE_W + ROW_W;
    localparam int ROWS   = NUM_PAGES * ROWS_PER_PAGE;
    localparam int OFF_W  = PAGE_SHIFT + PAGE_W;
    localparam int CMP_W  = (AP_W > 4) ? AP_W : 4;
    localparam int PHI_W  = 32 - PAGE_SHIFT;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CHK = 3'd3;
    localparam logic [2:0] ST_FREE_CHK = 3'd4;
    localparam logic [2:0] ST_FREE_UPD = 3'd5;
    localparam logic [2:0] ST_RESULT   = 3'd6;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [AP_W-1:0]   active_pages_reg;

    // Configuration registers.
    logic [31:0]       pool_base_reg;
    logic [3:0]        page_limit_reg;

    // Request and search registers.
    logic              dbl_reg;
    logic [31:0]       offset_reg;
    logic [PAGE_W-1:0] scan_page_reg;
    logic [ROW_W-1:0]  scan_row_reg;

    // Pending result.
    logic [1:0]        res_status_reg;
    logic              res_two_reg;
    logic              res_has_addr_reg;
    logic [OFF_W-1:0]  res_off_reg;

    // Output register.
    logic              m_tvalid_reg;
    logic [1:0]        m_status_reg;
    logic [31:0]       m_address_out_reg;
    logic              m_two_reg;

    // Slot marks memory.
    row_t              mem [ROWS];
    row_t              mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    row_t              mem_wdata;

    // Combinational helpers.
    logic              s_accept;
    logic              out_free;
    logic [ROW_SLOTS-1:0] cand;
    logic              hit;
    logic [LANE_W-1:0] hit_lane;
    logic              scan_last;
    logic              grow;
    logic [PHI_W-1:0]  free_page_hi;
    logic              free_ignored;
    logic [ADDR_W-1:0] free_row_addr;
    logic [LANE_W-1:0] free_lane;
    logic              free_slot_free;
    logic              free_slot_dbl;
    row_t              fresh_row;

    // Marks a slot, and its partner for a pair, as taken.
    function automatic row_t take_word(row_t w, logic [LANE_W-1:0] lane, logic dbl);
        row_t r;
        r = w;
        r.free[lane] = 1'b0;
        r.dbl[lane]  = dbl;
        if (dbl) begin
            r.free[LANE_W'(lane + 1'b1)] = 1'b0;
            r.dbl[LANE_W'(lane + 1'b1)]  = 1'b0;
        end
        return r;
    endfunction

    // Releases a slot, and its partner when the slot starts a pair.
    function automatic row_t release_word(row_t w, logic [LANE_W-1:0] lane);
        row_t r;
        r = w;
        if (w.dbl[lane] && (lane != LANE_W'(ROW_SLOTS - 1))) begin
            r.free[LANE_W'(lane + 1'b1)] = 1'b1;
            r.dbl[LANE_W'(lane + 1'b1)]  = 1'b0;
        end
        r.free[lane] = 1'b1;
        r.dbl[lane]  = 1'b0;
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_two_reg, m_address_out_reg, m_status_reg};

    // Candidate slots in the row just read: a free slot, or the start of a free pair
    // inside one aligned group.
    always_comb begin
        for (int i = 0; i < ROW_SLOTS; i++) begin
            if (dbl_reg) begin
                if ((i & GROUP_MASK) != GROUP_MASK) begin
                    cand[i] = mem_rdata_reg.free[i]
                           && mem_rdata_reg.free[(i + 1) % ROW_SLOTS];
                end else begin
                    cand[i] = 1'b0;
                end
            end else begin
                cand[i] = mem_rdata_reg.free[i];
            end
        end
    end

    // Lowest candidate wins.
    always_comb begin
        hit_lane = '0;
        for (int i = ROW_SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit_lane = LANE_W'(i);
            end
        end
    end
    assign hit = |cand;

    // Search bookkeeping and page activation.
    assign scan_last = (scan_row_reg == ROW_W'(ROWS_PER_PAGE - 1)) && (scan_page_reg == '0);
    assign grow = (CMP_W'(active_pages_reg) < CMP_W'(NUM_PAGES))
               && (CMP_W'(active_pages_reg) < CMP_W'(page_limit_reg));

    // A newly active page was cleared after reset and never written since.
    always_comb begin
        fresh_row.free = '1;
        fresh_row.dbl  = '0;
    end

    // Free address decode from the offset within the pool.
    assign free_page_hi  = offset_reg[31:PAGE_SHIFT];
    assign free_ignored  = (free_page_hi >= PHI_W'(active_pages_reg))
                        || (free_page_hi >= PHI_W'(NUM_PAGES));
    assign free_row_addr = offset_reg[OFF_W-1:PAGE_SHIFT-ROW_W];
    assign free_lane     = offset_reg[SLOT_SHIFT+LANE_W-1:SLOT_SHIFT];
    assign free_slot_free = mem_rdata_reg.free[free_lane];
    assign free_slot_dbl  = mem_rdata_reg.dbl[free_lane];

    // Next state and memory port control.
    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = free_row_addr;
        mem_wdata  = release_word(mem_rdata_reg, free_lane);
        mem_re     = 1'b0;
        mem_raddr  = {scan_page_reg, scan_row_reg};
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = fresh_row;
                if (clr_cnt_reg == ADDR_W'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == FUNC_FREE) begin
                        state_next = ST_FREE_CHK;
                    end else if (s_tdata[7:0] > MAX_SIZE) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                mem_re     = 1'b1;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (hit) begin
                    mem_we     = 1'b1;
                    mem_waddr  = {scan_page_reg, scan_row_reg};
                    mem_wdata  = take_word(mem_rdata_reg, hit_lane, dbl_reg);
                    state_next = ST_RESULT;
                end else if (scan_last) begin
                    if (grow) begin
                        mem_we    = 1'b1;
                        mem_waddr = {PAGE_W'(active_pages_reg), ROW_W'(0)};
                        mem_wdata = take_word(fresh_row, LANE_W'(0), dbl_reg);
                    end
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FREE_CHK: begin
                mem_raddr = free_row_addr;
                if (free_ignored) begin
                    state_next = ST_RESULT;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_FREE_UPD;
                end
            end
            ST_FREE_UPD: begin
                mem_we     = !free_slot_free;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Slot marks memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            active_pages_reg <= AP_W'(1);
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= ADDR_W'(clr_cnt_reg + 1'b1);
            end
            if ((state_reg == ST_SCAN_CHK) && !hit && scan_last && grow) begin
                active_pages_reg <= AP_W'(active_pages_reg + 1'b1);
            end
            if ((state_reg == ST_RESULT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg  <= '0;
            page_limit_reg <= PAGE_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_POOL_BASE:  pool_base_reg  <= cfg_wr_data;
                CFG_PAGE_LIMIT: page_limit_reg <= cfg_wr_data[3:0];
            endcase
        end
    end

    // Request, search and result datapath.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    dbl_reg          <= (s_tdata[7:0] > ONE_SLOT_SIZE);
                    offset_reg       <= s_tdata[39:8] - pool_base_reg;
                    scan_page_reg    <= PAGE_W'(active_pages_reg - 1'b1);
                    scan_row_reg     <= '0;
                    res_status_reg   <= STAT_TOO_LARGE;
                    res_two_reg      <= 1'b0;
                    res_has_addr_reg <= 1'b0;
                end
            end
            ST_SCAN_CHK: begin
                if (hit) begin
                    res_status_reg   <= STAT_OK;
                    res_two_reg      <= dbl_reg;
                    res_has_addr_reg <= 1'b1;
                    res_off_reg      <= {scan_page_reg, scan_row_reg, hit_lane,
                                         SLOT_SHIFT'(0)};
                end else if (scan_last) begin
                    if (grow) begin
                        res_status_reg   <= STAT_OK;
                        res_two_reg      <= dbl_reg;
                        res_has_addr_reg <= 1'b1;
                        res_off_reg      <= {PAGE_W'(active_pages_reg), ROW_W'(0),
                                             LANE_W'(0), SLOT_SHIFT'(0)};
                    end else begin
                        res_status_reg <= STAT_FULL;
                    end
                end else if (scan_row_reg == ROW_W'(ROWS_PER_PAGE - 1)) begin
                    // Page exhausted: move to the start of the next older page.
                    scan_row_reg  <= '0;
                    scan_page_reg <= PAGE_W'(scan_page_reg - 1'b1);
                end else begin
                    scan_row_reg <= ROW_W'(scan_row_reg + 1'b1);
                end
            end
            ST_FREE_CHK: begin
                res_status_reg <= STAT_IGNORED;
            end
            ST_FREE_UPD: begin
                if (!free_slot_free) begin
                    res_status_reg <= STAT_OK;
                    res_two_reg    <= free_slot_dbl;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_status_reg      <= res_status_reg;
                    m_two_reg         <= res_two_reg;
                    m_address_out_reg <= res_has_addr_reg
                                       ? pool_base_reg + 32'(res_off_reg) : 32'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // Checks on the sequencer and the result register.
    `SBA_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "ready held after an accepted item")
    `SBA_ASSERT_NOW(a_active_range, 1'b1, (active_pages_reg >= AP_W'(1)) && (active_pages_reg <= AP_W'(NUM_PAGES)), "active page count out of range")
    `SBA_ASSERT_NOW(a_active_step, $past(aresetn) && (active_pages_reg != $past(active_pages_reg)), active_pages_reg == AP_W'($past(active_pages_reg) + 1'b1), "active page count changed by more than one")
    `SBA_ASSERT_NOW(a_fail_no_addr, m_tvalid_reg && (m_status_reg != STAT_OK), (m_address_out_reg == 32'd0) && !m_two_reg, "failed request carries an address or pair flag")

endmodule
